[rtl/transfer_function_lut_engine_macros.svh]
// assertion macros for the transfer function lut engine
// used by the controller and the top level
`ifndef TRANSFER_FUNCTION_LUT_ENGINE_MACROS_SVH
`define TRANSFER_FUNCTION_LUT_ENGINE_MACROS_SVH
// implication checked every clock outside reset
`define TFL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define TFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/tfl_pkg.sv]
// package for the transfer function lut engine
// types, codes and constants; no dependencies
package tfl_pkg;
    localparam int DEF_MAX_DIM = 256;
    localparam int SIZE_W      = 9;
    localparam int MASK_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int TEXEL_W     = 24;
    localparam int DIV_STEPS   = 16;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_POINT  = 2'd1,
        OP_RAMP   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2,
        CFG_MASK   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_STEP
    } state_t;

    // request and result payloads
    typedef struct packed {
        op_t        op;
        logic [7:0] voxel;
        logic [7:0] point_x;
        logic [7:0] point_y;
    } tfl_req_t;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [TEXEL_W-1:0] texel_index;
        logic               last_voxel;
    } tfl_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic clear_write; // zero one table entry after reset
        logic lookup;     // accept a lookup request
        logic point;      // write single point; sets anchor on a point request
        logic ramp_start; // latch ramp endpoints
        logic div_start;  // begin division for current v, or next v with ramp_next
        logic ramp_write; // write quotient at current v
        logic ramp_next;  // advance v
    } tfl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last; // clearing pass at last entry
        logic ramp_flat;  // endpoints share x
        logic div_done;
        logic ramp_last;  // current v is x2
        logic out_busy;   // output register full and not taken
    } tfl_stat_t;
endpackage

[rtl/tfl_if.sv]
// valid/ready channel interface carrying a typed payload
// depends on nothing
interface tfl_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/tfl_ctrl.sv]
// controller for the transfer function lut engine
// depends on tfl_pkg and the macros header
`include "transfer_function_lut_engine_macros.svh"
module tfl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_op,
    output logic               in_ready,
    input  tfl_pkg::tfl_stat_t stat,
    output tfl_pkg::tfl_cmd_t  cmd
);
    import tfl_pkg::*;
    state_t state_reg, state_next;
    logic   acc;

    assign acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (acc && in_op == OP_RAMP)
                    state_next = ST_STEP;
            end
            ST_STEP:  state_next = stat.ramp_flat ? ST_IDLE : ST_DIV;
            ST_DIV:   if (stat.div_done) state_next = ST_WRITE;
            ST_WRITE: state_next = stat.ramp_last ? ST_IDLE : ST_DIV;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_write = 1'b1;
            ST_IDLE:
            begin
                in_ready = !stat.out_busy;
                cmd.lookup = acc && in_op == OP_LOOKUP;
                cmd.point = acc && in_op == OP_POINT;
                cmd.ramp_start = acc && in_op == OP_RAMP;
            end
            ST_STEP:
            begin
                cmd.point = stat.ramp_flat;
                cmd.div_start = !stat.ramp_flat;
            end
            ST_DIV: ;
            ST_WRITE:
            begin
                cmd.ramp_write = 1'b1;
                cmd.ramp_next = !stat.ramp_last;
                cmd.div_start = !stat.ramp_last;
            end
            default: ;
        endcase
    end

    `TFL_ASSERT_IMP(a_ready_idle, in_ready, state_reg == ST_IDLE, "ready outside idle")
    `TFL_ASSERT_IMP(a_one_edit, cmd.ramp_write, !cmd.point && !cmd.lookup, "edit overlap")
    `TFL_ASSERT_NEXT(a_ramp_go, cmd.ramp_start, state_reg == ST_STEP, "ramp not started")
endmodule

[rtl/tfl_datapath.sv]
// datapath: table memory, counters, ramp divider and output register
// depends on tfl_pkg
module tfl_datapath #(
    parameter int MAX_DIM = tfl_pkg::DEF_MAX_DIM
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tfl_pkg::tfl_cmd_t              cmd,
    output tfl_pkg::tfl_stat_t             stat,
    input  logic [7:0]                     voxel,
    input  logic [7:0]                     point_x,
    input  logic [7:0]                     point_y,
    input  logic                           cfg_we,
    input  logic [tfl_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [tfl_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     red,
    output logic [7:0]                     green,
    output logic [7:0]                     blue,
    output logic [7:0]                     alpha,
    output logic [tfl_pkg::TEXEL_W-1:0]    texel_index,
    output logic                           last_voxel
);
    import tfl_pkg::*;
    localparam int CW = $clog2(MAX_DIM) + 1;
    localparam int LW = $clog2(CW);

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [7:0] anchor_x_reg, anchor_y_reg;
    logic [CW-1:0] cnt_x_reg, cnt_y_reg, cnt_z_reg;
    logic [7:0] mem [256][4];
    logic [7:0] clr_reg;
    logic [7:0] x1_reg, x2_reg, y1_reg, y2_reg, v_reg;
    logic [15:0] num_reg, rem_reg;
    logic [15:0] quo_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic        oval_reg, pend_reg;
    logic [TEXEL_W-1:0] tex_reg;
    logic        last_reg;
    logic [7:0]  rd_reg [4];

    // effective sizes and log2 of padded sizes
    function automatic logic [CW-1:0] eff(input logic [SIZE_W-1:0] s);
        logic [SIZE_W+CW-1:0] w;
        w = {{CW{1'b0}}, s};
        if (s == '0) return CW'(1);
        if (w > (SIZE_W+CW)'(MAX_DIM)) return CW'(MAX_DIM);
        return CW'(s);
    endfunction
    function automatic logic [LW-1:0] clg(input logic [CW-1:0] s);
        logic [LW-1:0] r;
        r = '0;
        for (int i = CW-1; i >= 0; i--)
            if ((CW'(1) << i) >= s) r = LW'(i);
        return r;
    endfunction

    logic [CW-1:0] sx, sy, sz;
    logic [LW-1:0] lx, ly;
    logic [LW:0]   lxy;
    logic ex, ey, ez;
    logic [TEXEL_W-1:0] idx;
    assign sx = eff(size_x_reg);
    assign sy = eff(size_y_reg);
    assign sz = eff(size_z_reg);
    assign lx = clg(sx);
    assign ly = clg(sy);
    assign lxy = {1'b0, lx} + {1'b0, ly};
    assign ex = ({1'b0, cnt_x_reg} + 1'b1) >= {1'b0, sx};
    assign ey = ({1'b0, cnt_y_reg} + 1'b1) >= {1'b0, sy};
    assign ez = ({1'b0, cnt_z_reg} + 1'b1) >= {1'b0, sz};
    // index wraps at the texel width
    assign idx = TEXEL_W'(cnt_x_reg) + (TEXEL_W'(cnt_y_reg) << lx)
               + (TEXEL_W'(cnt_z_reg) << lxy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_W'(256);
            size_y_reg <= SIZE_W'(256);
            size_z_reg <= SIZE_W'(256);
            mask_reg <= MASK_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                CFG_MASK:   mask_reg <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // counters and anchor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_x_reg <= '0; cnt_y_reg <= '0; cnt_z_reg <= '0;
            anchor_x_reg <= '0; anchor_y_reg <= '0;
        end
        else
        begin
            if (cmd.lookup)
            begin
                if (!ex) cnt_x_reg <= cnt_x_reg + 1'b1;
                else
                begin
                    cnt_x_reg <= '0;
                    if (!ey) cnt_y_reg <= cnt_y_reg + 1'b1;
                    else
                    begin
                        cnt_y_reg <= '0;
                        cnt_z_reg <= ez ? '0 : cnt_z_reg + 1'b1;
                    end
                end
            end
            if (cmd.ramp_start)
            begin
                anchor_x_reg <= point_x;
                anchor_y_reg <= point_y;
            end
            else if (cmd.point && !cmd.ramp_write)
            begin
                // single point from a point request; flat ramp already set anchor
                if (!div_busy_reg && !pend_reg)
                begin
                    anchor_x_reg <= point_x;
                    anchor_y_reg <= point_y;
                end
            end
        end
    end

    // clearing pass over the table after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_write)
            clr_reg <= clr_reg + 1'b1;
    end
    assign stat.clear_last = (clr_reg == 8'hFF);

    // ramp endpoints; new point stays in x1 when equal; pend marks active ramp
    logic [7:0] num_dx;
    assign num_dx = x2_reg - x1_reg;
    assign stat.ramp_flat = (num_dx == '0);
    assign stat.ramp_last = (v_reg == x2_reg);

    // divider: (y1*(dx-t)+y2*t) / dx, restoring, one bit per cycle
    logic [15:0] num_now;
    logic [7:0]  tt;
    assign tt = v_reg - x1_reg;
    assign num_now = y1_reg * 8'(num_dx - tt) + y2_reg * tt;
    logic [16:0] trial;
    assign trial = {rem_reg, num_reg[15]} - {9'd0, num_dx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            div_cnt_reg <= '0;
            x1_reg <= '0; y1_reg <= '0;
            x2_reg <= '0; y2_reg <= '0;
            v_reg <= '0;
            num_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else
        begin
            if (cmd.ramp_start)
            begin
                pend_reg <= 1'b1;
                if (anchor_x_reg < point_x)
                begin
                    x1_reg <= anchor_x_reg; y1_reg <= anchor_y_reg;
                    x2_reg <= point_x; y2_reg <= point_y;
                    v_reg <= anchor_x_reg;
                end
                else
                begin
                    x1_reg <= point_x; y1_reg <= point_y;
                    x2_reg <= anchor_x_reg; y2_reg <= anchor_y_reg;
                    v_reg <= point_x;
                end
            end
            else if (cmd.point && pend_reg)
                pend_reg <= 1'b0;
            if (cmd.ramp_write && !cmd.ramp_next)
                pend_reg <= 1'b0;
            if (cmd.ramp_next)
                v_reg <= v_reg + 1'b1;
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg <= '0;
                rem_reg <= '0;
                quo_reg <= '0;
                num_reg <= cmd.ramp_next ? (y1_reg * 8'(num_dx - 8'(tt + 1'b1))
                         + y2_reg * 8'(tt + 1'b1)) : num_now;
            end
            else if (div_busy_reg)
            begin
                if (!trial[16])
                begin
                    rem_reg <= trial[15:0];
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[14:0], num_reg[15]};
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
                num_reg <= {num_reg[14:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == 5'(DIV_STEPS-1))
                    div_busy_reg <= 1'b0;
            end
        end
    end
    assign stat.div_done = !div_busy_reg && !cmd.div_start;

    // table write port
    logic              we;
    logic [7:0]        wa, wd;
    logic [MASK_W-1:0] wm;
    always_comb
    begin
        we = 1'b0; wa = point_x; wd = point_y; wm = mask_reg;
        if (cmd.clear_write)
        begin
            we = 1'b1; wa = clr_reg; wd = 8'd0; wm = '1;
        end
        else if (cmd.ramp_write)
        begin
            we = 1'b1; wa = v_reg;
            wd = (quo_reg > 16'd255) ? 8'hFF : quo_reg[7:0];
        end
        else if (cmd.point)
        begin
            we = 1'b1;
            if (pend_reg) begin wa = x1_reg; wd = y1_reg; end
        end
    end

    // read data captured only on lookup so it holds while the result stalls
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
            if (we && wm[c]) mem[wa][c] <= wd;
        if (cmd.lookup)
            for (int c = 0; c < 4; c++)
                rd_reg[c] <= mem[voxel][c];
    end

    // output register; valid, index and read data registered on lookup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oval_reg <= 1'b0;
            tex_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.lookup)
            begin
                oval_reg <= 1'b1;
                tex_reg <= idx;
                last_reg <= ex && ey && ez;
            end
            else if (out_ready)
                oval_reg <= 1'b0;
        end
    end

    assign stat.out_busy = oval_reg && !out_ready;
    assign out_valid = oval_reg;
    assign red   = rd_reg[0];
    assign green = rd_reg[1];
    assign blue  = rd_reg[2];
    assign alpha = rd_reg[3];
    assign texel_index = tex_reg;
    assign last_voxel = last_reg;
endmodule

[rtl/transfer_function_lut_engine.sv]
// top level of the transfer function lut engine
// depends on tfl_pkg, tfl_if, tfl_ctrl, tfl_datapath
//
// channel    dir  payload
// req        in   op, voxel, point_x, point_y
// rsp        out  red, green, blue, alpha, texel_index, last_voxel
// cfg        in   cfg_we, cfg_index, cfg_data
//
// after reset a clearing pass zeroes the table, with req.ready low
// a lookup result is registered the cycle after the request; one lookup per cycle unless the result stalls
// a point edit is written when accepted; a flat ramp latches its endpoints, then writes one point in the step state
// a ramp holds the request side off through the step state and a divide and write per entry (16-step serial divider)
// a stalled result holds the next request off
`include "transfer_function_lut_engine_macros.svh"
module transfer_function_lut_engine #(
    parameter int MAX_DIM = tfl_pkg::DEF_MAX_DIM
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tfl_if.sink                            req,
    tfl_if.source                          rsp,
    input  logic                           cfg_we,
    input  logic [tfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tfl_pkg::*;
    tfl_cmd_t  cmd;
    tfl_stat_t stat;

    // controller sequences edits; datapath holds table and counters
    tfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.data.op),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfl_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .voxel       (req.data.voxel),
        .point_x     (req.data.point_x),
        .point_y     (req.data.point_y),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .red         (rsp.data.red),
        .green       (rsp.data.green),
        .blue        (rsp.data.blue),
        .alpha       (rsp.data.alpha),
        .texel_index (rsp.data.texel_index),
        .last_voxel  (rsp.data.last_voxel)
    );

    // a held result blocks new requests
    `TFL_ASSERT_IMP(a_hold, rsp.valid && !rsp.ready, !req.ready, "request taken over stall")
    // a stalled result stays put
    `TFL_ASSERT_NEXT(a_rsp_stable, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data), "result changed under stall")
    // offered results carry known data
    `TFL_ASSERT_IMP(a_rsp_known, rsp.valid, !$isunknown(rsp.data), "result payload unknown")
endmodule
